/* design/adw_pkg.sv */
package adw_pkg;

	typedef enum logic [1:0] {
		REG_DRIVE_GAIN = 2'd0,
		REG_THRESHOLD  = 2'd1,
		REG_SHAPE_MODE = 2'd2,
		REG_POST_GAIN  = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_HARD_CLIP = 2'd0,
		MODE_TANH      = 2'd1,
		MODE_SOFT_KNEE = 2'd2,
		MODE_BYPASS    = 2'd3
	} shape_mode_t;

	typedef struct packed {
		logic s4;
		logic s5;
		logic s6;
	} tanh_en_t;

	localparam int ADDR_BITS   = 4;
	localparam int DATA_BITS   = 32;
	localparam int DRIVE_BITS  = 16;
	localparam int THRESH_BITS = 14;
	localparam int POST_BITS   = 17;
	localparam int GAIN_FRAC   = 12;

	localparam logic [DRIVE_BITS-1:0]  DRIVE_RESET  = 16'd4096;
	localparam logic [THRESH_BITS-1:0] THRESH_RESET = 14'd256;
	localparam logic [POST_BITS-1:0]   POST_RESET   = 17'd4096;

	localparam logic [THRESH_BITS-1:0] KNEE_BASE = 14'd13056;

	localparam int DIV_BASE    = 25;
	localparam int DIV_BIAS    = 12;
	localparam int DIV25_MUL   = 20972;
	localparam int DIV25_SHIFT = 19;
	localparam int QUOT_BITS   = 10;
	localparam int REM_BITS    = 5;

	localparam int ROM_BITS     = 32;
	localparam int ROM_FRAC     = 31;
	localparam int FW_BITS      = 14;
	localparam int SERIES_TERMS = 24;
	localparam longint unsigned ONE62 = 64'd1 << 62;

endpackage

/* design/adw_tanh.sv */
module adw_tanh
	import adw_pkg::*;
#(
	parameter int SAMPLE_BITS     = 24,
	parameter int TANH_TABLE_BITS = 10,
	parameter int ARG_BITS        = 43
) (
	input  logic                   clk,
	input  tanh_en_t               en,
	input  logic [ARG_BITS-1:0]    arg,
	output logic [SAMPLE_BITS-1:0] mag
);

	localparam int FRAC   = SAMPLE_BITS - 1;
	localparam int TB     = TANH_TABLE_BITS;
	localparam int ROM_N  = 1 << TB;
	localparam int HALF_N = ROM_N / 2;
	localparam int SH     = FRAC + 11 - TB;
	localparam int FW_LO  = SH - FW_BITS;
	localparam int TS     = ROM_FRAC - FRAC;
	localparam int PRODW  = ROM_BITS + 1 + FW_BITS + 2;
	localparam int SUMW   = PRODW + 1;
	localparam longint RND_HALF = (64'sd1 << TS) >>> 1;

	typedef logic [ROM_BITS-1:0] rom_t [ROM_N+1];
	typedef logic [ROM_BITS-1:0] even_t [HALF_N+1];
	typedef logic [ROM_BITS-1:0] odd_t [HALF_N];

	function automatic longint unsigned udiv(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = 64'd0;
		r = 64'd0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], num[i]};
			if (r >= den) begin
				r = r - den;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic longint unsigned mul62(input longint unsigned a,
			input longint unsigned b);
		longint unsigned m31;
		longint unsigned lo;
		longint unsigned mid;
		longint unsigned hi;
		m31 = (64'd1 << 31) - 64'd1;
		lo  = (a & m31) * (b & m31);
		mid = (a >> 31) * (b & m31) + (a & m31) * (b >> 31);
		hi  = (a >> 31) * (b >> 31);
		return hi + ((mid + (lo >> 31)) >> 31);
	endfunction

	function automatic rom_t build_rom();
		rom_t rom;
		longint unsigned term;
		longint unsigned e;
		longint unsigned p;
		longint unsigned p32;
		longint unsigned num;
		longint unsigned den;
		term = ONE62;
		e    = ONE62;
		p    = ONE62;
		for (int k = 1; k <= SERIES_TERMS; k++) begin
			term = udiv(term >> (TB - 4), 64'(k));
			if (k[0])
				e = e - term;
			else
				e = e + term;
		end
		for (int i = 0; i <= ROM_N; i++) begin
			p32 = p >> 30;
			num = (64'd1 << 32) - p32;
			den = (64'd1 << 32) + p32;
			rom[i] = ROM_BITS'(udiv((num << 31) + (den >> 1), den));
			p = mul62(p, e);
		end
		return rom;
	endfunction

	function automatic even_t pick_even(input rom_t r);
		even_t b;
		for (int j = 0; j <= HALF_N; j++)
			b[j] = r[2*j];
		return b;
	endfunction

	function automatic odd_t pick_odd(input rom_t r);
		odd_t b;
		for (int j = 0; j < HALF_N; j++)
			b[j] = r[2*j+1];
		return b;
	endfunction

	localparam rom_t  TANH_ROM = build_rom();
	localparam even_t EVEN_ROM = pick_even(TANH_ROM);
	localparam odd_t  ODD_ROM  = pick_odd(TANH_ROM);

	logic              sat;
	logic [TB-1:0]     idx;
	logic [FW_BITS:0]  fw;
	logic [TB-2:0]     half_idx;
	logic [TB-1:0]     even_addr;

	logic [ROM_BITS-1:0] even_s4;
	logic [ROM_BITS-1:0] odd_s4;
	logic                par_s4;
	logic [FW_BITS:0]    fw_s4;

	logic [ROM_BITS-1:0]     lo_c;
	logic [ROM_BITS-1:0]     hi_c;
	logic signed [ROM_BITS:0] diff_c;
	logic signed [PRODW-1:0] prod_c;

	logic [ROM_BITS-1:0]     lo_s5;
	logic signed [PRODW-1:0] prod_s5;

	logic signed [PRODW-1:0] step;
	logic signed [SUMW-1:0]  ysum;
	logic signed [SUMW-1:0]  yrnd;

	// past the last table step, interpolate the last step to its end
	assign sat       = |arg[ARG_BITS-1:SH+TB];
	assign idx       = sat ? {TB{1'b1}} : arg[SH+TB-1:SH];
	assign fw        = sat ? (FW_BITS+1)'(1 << FW_BITS) : {1'b0, arg[SH-1:FW_LO]};
	assign half_idx  = idx[TB-1:1];
	assign even_addr = {1'b0, half_idx} + TB'(idx[0]);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			even_s4 <= EVEN_ROM[even_addr];
			odd_s4  <= ODD_ROM[half_idx];
			par_s4  <= idx[0];
			fw_s4   <= fw;
		end
	end

	assign lo_c   = par_s4 ? odd_s4 : even_s4;
	assign hi_c   = par_s4 ? even_s4 : odd_s4;
	assign diff_c = $signed({1'b0, hi_c}) - $signed({1'b0, lo_c});
	assign prod_c = diff_c * $signed({1'b0, fw_s4});

	always_ff @(posedge clk) begin
		if (en.s5) begin
			lo_s5   <= lo_c;
			prod_s5 <= prod_c;
		end
	end

	assign step = prod_s5 >>> FW_BITS;
	assign ysum = $signed({{(SUMW-ROM_BITS){1'b0}}, lo_s5}) + $signed({step[PRODW-1], step});
	assign yrnd = (ysum + SUMW'(RND_HALF)) >>> TS;

	always_ff @(posedge clk) begin
		if (en.s6) begin
			mag <= yrnd[SAMPLE_BITS-1:0];
		end
	end

endmodule

/* design/audio_distortion_waveshaper_unit.sv */
// Each sample passes through stage registers s1 to s8 on its way to sample_out.
// Throughput: one sample per cycle while out_stall is low; every stage
// of the 8-stage pipeline holds one sample; a stall holds only full stages.
// Reset: clears all stage valid bits and loads the register reset values.
// The tanh table is a fixed ROM and needs no initialization.
module audio_distortion_waveshaper_unit
	import adw_pkg::*;
#(
	parameter int SAMPLE_BITS     = 24,
	parameter int TANH_TABLE_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_BITS-1:0]          paddr,
	input  logic [DATA_BITS-1:0]          pwdata,
	output logic [DATA_BITS-1:0]          prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);

	localparam int FRAC     = SAMPLE_BITS - 1;
	localparam int PW       = SAMPLE_BITS + DRIVE_BITS + 1;
	localparam int DW       = PW - GAIN_FRAC;
	localparam int ARG_BITS = THRESH_BITS + DW;
	localparam int ZW       = DW + POST_BITS + 1;
	localparam int ZSW      = ZW - GAIN_FRAC;
	localparam int LP       = FRAC - 11;
	localparam int KP       = FRAC - 10;
	localparam int QPW      = THRESH_BITS + 15;
	localparam longint unsigned CEIL_U =
		((64'd1 << FRAC) * 64'd988553095 + 64'd500000000) / 64'd1000000000;
	localparam logic signed [ZSW-1:0] CEIL_POS = ZSW'(CEIL_U);
	localparam logic signed [ZSW-1:0] CEIL_NEG = -CEIL_POS;
	localparam logic signed [PW-1:0]  DRIVE_HALF = PW'(1) << (GAIN_FRAC - 1);
	localparam logic signed [ZW-1:0]  POST_HALF  = ZW'(1) << (GAIN_FRAC - 1);

	typedef logic [KP-1:0] frac_tab_t [32];

	function automatic frac_tab_t build_frac_tab(input int p);
		frac_tab_t tab;
		for (int b = 0; b < 32; b++)
			tab[b] = (b < DIV_BASE) ?
				KP'(((longint'(b) << p) + DIV_BIAS) / DIV_BASE) : '0;
		return tab;
	endfunction

	localparam frac_tab_t LIM_TAB  = build_frac_tab(LP);
	localparam frac_tab_t KNEE_TAB = build_frac_tab(KP);

	logic [DRIVE_BITS-1:0]  drive_gain_q;
	logic [THRESH_BITS-1:0] threshold_q;
	shape_mode_t            shape_mode_q;
	logic [POST_BITS-1:0]   post_gain_q;

	logic     cfg_wr;
	reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_BITS-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_gain_q <= DRIVE_RESET;
			threshold_q  <= THRESH_RESET;
			shape_mode_q <= MODE_HARD_CLIP;
			post_gain_q  <= POST_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_DRIVE_GAIN: drive_gain_q <= pwdata[DRIVE_BITS-1:0];
				REG_THRESHOLD:  threshold_q  <= pwdata[THRESH_BITS-1:0];
				REG_SHAPE_MODE: shape_mode_q <= shape_mode_t'(pwdata[1:0]);
				REG_POST_GAIN:  post_gain_q  <= pwdata[POST_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_DRIVE_GAIN: prdata = DATA_BITS'(drive_gain_q);
			REG_THRESHOLD:  prdata = DATA_BITS'(threshold_q);
			REG_SHAPE_MODE: prdata = DATA_BITS'(shape_mode_q);
			REG_POST_GAIN:  prdata = DATA_BITS'(post_gain_q);
			default:        prdata = '0;
		endcase
	end

	// pipeline flow control
	logic [8:1] en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	assign en[8]    = !v_s8 || !out_stall;
	assign en[7]    = !v_s7 || en[8];
	assign en[6]    = !v_s6 || en[7];
	assign en[5]    = !v_s5 || en[6];
	assign en[4]    = !v_s4 || en[5];
	assign en[3]    = !v_s3 || en[4];
	assign en[2]    = !v_s2 || en[3];
	assign en[1]    = !v_s1 || en[2];
	assign in_stall = !en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en[1]) v_s1 <= in_valid;
			if (en[2]) v_s2 <= v_s1;
			if (en[3]) v_s3 <= v_s2;
			if (en[4]) v_s4 <= v_s3;
			if (en[5]) v_s5 <= v_s4;
			if (en[6]) v_s6 <= v_s5;
			if (en[7]) v_s7 <= v_s6;
			if (en[8]) v_s8 <= v_s7;
		end
	end

	// stage 1: drive product, knee base minus threshold divided by 25
	logic signed [PW-1:0]   prod_c;
	logic [THRESH_BITS-1:0] t2_c;
	logic [QPW-1:0]         qprod_c;

	logic signed [PW-1:0]   prod_s1;
	logic [THRESH_BITS-1:0] t2_s1;
	logic [QUOT_BITS-1:0]   quot_s1;

	assign prod_c  = $signed(sample_in) * $signed({1'b0, drive_gain_q});
	assign t2_c    = (threshold_q > KNEE_BASE) ? '0 : KNEE_BASE - threshold_q;
	assign qprod_c = QPW'(t2_c) * QPW'(DIV25_MUL);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			prod_s1 <= prod_c;
			t2_s1   <= t2_c;
			quot_s1 <= qprod_c[DIV25_SHIFT+QUOT_BITS-1:DIV25_SHIFT];
		end
	end

	// stage 2: round driven sample, build clip and knee levels
	logic signed [PW-1:0]   dsum_c;
	logic [THRESH_BITS-1:0] q25_c;
	logic [THRESH_BITS-1:0] rdiff_c;
	logic [REM_BITS-1:0]    rem_c;

	logic signed [DW-1:0] d_s2;
	logic [FRAC-1:0]      lim_s2;
	logic [FRAC-1:0]      knee_s2;

	assign dsum_c  = prod_s1 + DRIVE_HALF;
	assign q25_c   = THRESH_BITS'(quot_s1) * THRESH_BITS'(DIV_BASE);
	assign rdiff_c = t2_s1 - q25_c;
	assign rem_c   = rdiff_c[REM_BITS-1:0];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			d_s2    <= dsum_c[PW-1:GAIN_FRAC];
			lim_s2  <= FRAC'({quot_s1, LIM_TAB[rem_c][LP-1:0]});
			knee_s2 <= FRAC'({quot_s1, KNEE_TAB[rem_c]});
		end
	end

	// stage 3: clip and knee shaping, tanh argument
	logic signed [DW-1:0]  lim_x;
	logic signed [DW-1:0]  knee_x;
	logic signed [DW-1:0]  clip_c;
	logic signed [DW-1:0]  soft_c;
	logic signed [DW-1:0]  ysh_c;
	logic [DW-1:0]         dmag_c;
	logic [ARG_BITS-1:0]   arg_c;

	logic signed [DW-1:0]  ysh_s3;
	logic                  neg_s3;
	logic [ARG_BITS-1:0]   arg_s3;

	assign lim_x  = $signed(DW'(lim_s2));
	assign knee_x = $signed(DW'(knee_s2));

	always_comb begin
		if (d_s2 >= lim_x)
			clip_c = lim_x;
		else if (d_s2 <= -lim_x)
			clip_c = -lim_x;
		else
			clip_c = d_s2;

		if (d_s2 >= knee_x)
			soft_c = ((d_s2 - knee_x) >>> 1) + knee_x;
		else if (d_s2 <= -knee_x)
			soft_c = ((d_s2 + knee_x) >>> 1) - knee_x;
		else
			soft_c = d_s2;

		case (shape_mode_q)
			MODE_HARD_CLIP: ysh_c = clip_c;
			MODE_SOFT_KNEE: ysh_c = soft_c;
			default:        ysh_c = d_s2;
		endcase
	end

	assign dmag_c = d_s2[DW-1] ? DW'(-d_s2) : DW'(d_s2);
	assign arg_c  = ARG_BITS'(threshold_q) * ARG_BITS'(dmag_c);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			ysh_s3 <= ysh_c;
			neg_s3 <= d_s2[DW-1];
			arg_s3 <= arg_c;
		end
	end

	// stages 4 to 6: table read and interpolation
	tanh_en_t               tanh_en;
	logic [SAMPLE_BITS-1:0] tanh_mag_s6;

	assign tanh_en.s4 = en[4];
	assign tanh_en.s5 = en[5];
	assign tanh_en.s6 = en[6];

	adw_tanh #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.TANH_TABLE_BITS (TANH_TABLE_BITS),
		.ARG_BITS        (ARG_BITS)
	) u_tanh (
		.clk (clk),
		.en  (tanh_en),
		.arg (arg_s3),
		.mag (tanh_mag_s6)
	);

	logic signed [DW-1:0] ysh_s4, ysh_s5, ysh_s6;
	logic                 neg_s4, neg_s5, neg_s6;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			ysh_s4 <= ysh_s3;
			neg_s4 <= neg_s3;
		end
		if (en[5]) begin
			ysh_s5 <= ysh_s4;
			neg_s5 <= neg_s4;
		end
		if (en[6]) begin
			ysh_s6 <= ysh_s5;
			neg_s6 <= neg_s5;
		end
	end

	// stage 7: select shaped sample, post gain
	logic signed [DW-1:0] tpos_c;
	logic signed [DW-1:0] tsig_c;
	logic signed [DW-1:0] y_c;
	logic signed [ZW-1:0] z_c;

	logic signed [ZW-1:0] z_s7;

	assign tpos_c = $signed(DW'(tanh_mag_s6));
	assign tsig_c = neg_s6 ? -tpos_c : tpos_c;
	assign y_c    = (shape_mode_q == MODE_TANH) ? tsig_c : ysh_s6;
	assign z_c    = y_c * $signed({1'b0, post_gain_q});

	always_ff @(posedge clk) begin
		if (en[7]) begin
			z_s7 <= z_c;
		end
	end

	// stage 8: round and limit to the ceiling
	logic signed [ZW-1:0]  zsum_c;
	logic signed [ZSW-1:0] zr_c;
	logic signed [ZSW-1:0] zc_c;

	logic signed [SAMPLE_BITS-1:0] out_s8;

	assign zsum_c = z_s7 + POST_HALF;
	assign zr_c   = zsum_c[ZW-1:GAIN_FRAC];

	always_comb begin
		if (zr_c > CEIL_POS)
			zc_c = CEIL_POS;
		else if (zr_c < CEIL_NEG)
			zc_c = CEIL_NEG;
		else
			zc_c = zr_c;
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			out_s8 <= zc_c[SAMPLE_BITS-1:0];
		end
	end

	assign out_valid  = v_s8;
	assign sample_out = out_s8;

endmodule

/* verif/tb_audio_distortion_waveshaper_unit.sv */
module tb_audio_distortion_waveshaper_unit;
	import adw_pkg::*;

	localparam int SW        = 24;
	localparam int TBL_BITS  = 10;
	localparam int FRACB     = SW - 1;
	localparam int ROM_N     = 1 << TBL_BITS;
	localparam int POS_SHIFT = FRACB + 11 - TBL_BITS;
	localparam longint CEIL_Q =
		((longint'(1) << FRACB) * 988553095 + 500000000) / 1000000000;
	localparam int LIMIT     = 400000;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  psel      = 1'b0;
	logic                  penable   = 1'b0;
	logic                  pwrite    = 1'b0;
	logic [ADDR_BITS-1:0]  paddr     = '0;
	logic [DATA_BITS-1:0]  pwdata    = '0;
	logic [DATA_BITS-1:0]  prdata;
	logic                  pready;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	logic signed [SW-1:0]  sample_in = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic signed [SW-1:0]  sample_out;

	logic [DRIVE_BITS-1:0]  drive_cfg  = DRIVE_RESET;
	logic [THRESH_BITS-1:0] thresh_cfg = THRESH_RESET;
	shape_mode_t            mode_cfg   = MODE_HARD_CLIP;
	logic [POST_BITS-1:0]   post_cfg   = POST_RESET;

	longint unsigned tanh_rom [0:ROM_N];

	logic signed [SW-1:0] samples_todo [$];
	logic signed [SW-1:0] expected_out [$];

	bit          in_taken    = 1'b0;
	bit          steady      = 1'b0;
	int unsigned hold_req    = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left   = 0;
	int unsigned mismatches  = 0;
	int unsigned cycles      = 0;

	audio_distortion_waveshaper_unit #(
		.SAMPLE_BITS(SW),
		.TANH_TABLE_BITS(TBL_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_in(sample_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_out(sample_out)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint unsigned mul_q62(longint unsigned a, longint unsigned b);
		longint unsigned m31, a1, a0, b1, b0, lo, mid, hi;
		m31 = (64'd1 << 31) - 1;
		a1 = a >> 31;
		a0 = a & m31;
		b1 = b >> 31;
		b0 = b & m31;
		lo = a0 * b0;
		mid = a1 * b0 + a0 * b1;
		hi = a1 * b1;
		return hi + ((mid + (lo >> 31)) >> 31);
	endfunction

	function automatic void build_tanh_rom();
		longint unsigned term, e2h, p, p32, num, den;
		term = ONE62;
		e2h = ONE62;
		p = ONE62;
		for (int k = 1; k <= SERIES_TERMS; k++) begin
			term = (term >> (TBL_BITS - 4)) / k;
			if (k % 2 == 1) begin
				e2h = e2h - term;
			end else begin
				e2h = e2h + term;
			end
		end
		for (int i = 0; i <= ROM_N; i++) begin
			p32 = p >> 30;
			num = (64'd1 << 32) - p32;
			den = (64'd1 << 32) + p32;
			tanh_rom[i] = ((num << 31) + den / 2) / den;
			p = mul_q62(p, e2h);
		end
	endfunction

	function automatic longint tanh_curve(longint d);
		longint th, mag, a, idx, fw, lo, diff, y;
		th = longint'(thresh_cfg);
		mag = (d < 0) ? -d : d;
		a = th * mag;
		idx = a >>> POS_SHIFT;
		if (idx >= ROM_N) begin
			y = tanh_rom[ROM_N];
		end else begin
			fw = (a & ((longint'(1) << POS_SHIFT) - 1)) >>> (POS_SHIFT - FW_BITS);
			lo = tanh_rom[idx];
			diff = tanh_rom[idx + 1] - lo;
			y = lo + ((diff * fw) >>> FW_BITS);
		end
		y = (y + (longint'(1) << (ROM_FRAC - FRACB - 1))) >>> (ROM_FRAC - FRACB);
		return (d < 0) ? -y : y;
	endfunction

	function automatic logic signed [SW-1:0] shaped_sample(logic signed [SW-1:0] smp);
		longint x, dg, pg, d, t2, lim, knee, y, z;
		x = longint'(smp);
		dg = longint'(drive_cfg);
		pg = longint'(post_cfg);
		d = (x * dg + 2048) >>> GAIN_FRAC;
		t2 = longint'(KNEE_BASE);
		t2 = t2 - longint'(thresh_cfg);
		if (t2 < 0) begin
			t2 = 0;
		end
		case (mode_cfg)
			MODE_HARD_CLIP: begin
				lim = ((t2 << FRACB) + 25600) / 51200;
				y = d;
				if (y >= lim) begin
					y = lim;
				end else if (y <= -lim) begin
					y = -lim;
				end
			end
			MODE_TANH: begin
				y = tanh_curve(d);
			end
			MODE_SOFT_KNEE: begin
				knee = ((t2 << FRACB) + 12800) / 25600;
				if (d >= knee) begin
					y = ((d - knee) >>> 1) + knee;
				end else if (d <= -knee) begin
					y = ((d + knee) >>> 1) - knee;
				end else begin
					y = d;
				end
			end
			default: begin
				y = d;
			end
		endcase
		z = (y * pg + 2048) >>> GAIN_FRAC;
		if (z > CEIL_Q) begin
			z = CEIL_Q;
		end else if (z < -CEIL_Q) begin
			z = -CEIL_Q;
		end
		return z[SW-1:0];
	endfunction

	function automatic logic signed [SW-1:0] pick_sample();
		int unsigned k;
		logic signed [SW-1:0] v;
		k = $urandom_range(1, SW - 1);
		case ($urandom_range(0, 3))
			0, 1: begin
				v = SW'($urandom);
			end
			2: begin
				v = SW'($urandom & ((32'd1 << k) - 1));
				if ($urandom_range(0, 1) == 1) begin
					v = -v;
				end
			end
			default: begin
				if ($urandom_range(0, 1) == 1) begin
					v = {1'b0, {(SW-1){1'b1}}} - SW'($urandom_range(0, 255));
				end else begin
					v = {1'b1, {(SW-1){1'b0}}} + SW'($urandom_range(0, 255));
				end
			end
		endcase
		return v;
	endfunction

	task automatic queue_sample(logic signed [SW-1:0] v);
		samples_todo.insert(samples_todo.size(), v);
	endtask

	task automatic load_directed();
		queue_sample({1'b0, {(SW-1){1'b1}}});
		queue_sample({1'b1, {(SW-1){1'b0}}});
		queue_sample(SW'(0));
		queue_sample(SW'(1));
		queue_sample(SW'(-1));
		queue_sample(SW'(1 <<< (SW - 2)));
	endtask

	task automatic reg_write(reg_idx_t idx, logic [DATA_BITS-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_DRIVE_GAIN: drive_cfg = value[DRIVE_BITS-1:0];
			REG_THRESHOLD:  thresh_cfg = value[THRESH_BITS-1:0];
			REG_SHAPE_MODE: mode_cfg = shape_mode_t'(value[1:0]);
			default:        post_cfg = value[POST_BITS-1:0];
		endcase
	endtask

	task automatic drain();
		while (samples_todo.size() != 0 || expected_out.size() != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic run_phase(logic [DATA_BITS-1:0] dg, logic [DATA_BITS-1:0] th,
			shape_mode_t md, logic [DATA_BITS-1:0] pg, int n_rand, bit directed,
			bit quiet, bit hold);
		reg_write(REG_DRIVE_GAIN, dg);
		reg_write(REG_THRESHOLD, th);
		reg_write(REG_SHAPE_MODE, {30'd0, md});
		reg_write(REG_POST_GAIN, pg);
		steady = quiet;
		if (hold) begin
			hold_req++;
		end
		if (directed) begin
			load_directed();
		end
		repeat (n_rand) queue_sample(pick_sample());
		drain();
		steady = 1'b0;
	endtask

	// record accepted sample transfers and drive the next sample
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			expected_out.insert(expected_out.size(), shaped_sample(sample_in));
			void'(samples_todo.pop_front());
			in_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (!(in_valid && !in_taken)) begin
			if (samples_todo.size() != 0 && (steady || $urandom_range(0, 99) >= 23)) begin
				in_valid <= 1'b1;
				sample_in <= samples_todo[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
		in_taken = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_served != hold_req) begin
			hold_served = hold_req;
			hold_left = 150;
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= !steady && ($urandom_range(0, 99) < 23);
		end
	end

	// check result transfers
	always @(posedge clk) begin
		logic signed [SW-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_out.size() == 0) begin
				$display("%0t unexpected sample_out: expected none actual %0d",
					$time, sample_out);
				mismatches++;
			end else begin
				want = expected_out.pop_front();
				if (sample_out !== want) begin
					$display("%0t sample_out mismatch: expected %0d actual %0d",
						$time, want, sample_out);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_audio_distortion_waveshaper_unit: errors");
			$finish;
		end
	end

	initial begin
		logic [DATA_BITS-1:0] dg, th, pg;
		shape_mode_t md;
		build_tanh_rom();
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		load_directed();
		drain();
		run_phase(40960, 12800, MODE_TANH, 4096, 0, 1'b1, 1'b0, 1'b0);
		run_phase(1229, 16383, MODE_SOFT_KNEE, 91712, 0, 1'b1, 1'b0, 1'b0);
		run_phase(65535, 0, MODE_BYPASS, 131071, 0, 1'b1, 1'b0, 1'b0);

		for (int p = 0; p < 16; p++) begin
			md = shape_mode_t'(p[1:0]);
			case ($urandom_range(0, 4))
				0: dg = 1229;
				1: dg = 40960;
				2: dg = 4096;
				3: dg = 65535;
				default: dg = $urandom_range(1229, 40960);
			endcase
			case ($urandom_range(0, 4))
				0: th = 256;
				1: th = 12800;
				2: th = $urandom_range(12801, 16383);
				3: th = $urandom_range(0, 255);
				default: th = $urandom_range(256, 12800);
			endcase
			case ($urandom_range(0, 4))
				0: pg = 183;
				1: pg = 91712;
				2: pg = 4096;
				3: pg = $urandom_range(0, 131071);
				default: pg = $urandom_range(183, 91712);
			endcase
			if (p == 0) begin
				dg = 1229;
				th = 256;
				pg = 183;
			end else if (p == 1) begin
				dg = 40960;
				th = 12800;
				pg = 91712;
			end
			run_phase(dg, th, md, pg, 95, 1'b0, p == 3, p == 6);
		end

		if (mismatches == 0) begin
			$display("tb_audio_distortion_waveshaper_unit: clean");
		end else begin
			$display("tb_audio_distortion_waveshaper_unit: errors");
		end
		$finish;
	end

endmodule
